### hdl/php_pkg.sv
// ----------------------------------------------------------------------------
// php_pkg
// Shared types, codes and signature tables for the header pre-classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package php_pkg;

    // result kinds
    localparam logic [1:0] KIND_NEED_MORE = 2'd0;
    localparam logic [1:0] KIND_TEXT      = 2'd1;
    localparam logic [1:0] KIND_BINARY    = 2'd2;
    localparam logic [1:0] KIND_NOT_PROXY = 2'd3;

    // configuration register indexes
    localparam logic CFG_TEXT_MAX_LEN = 1'b0;
    localparam logic CFG_BIN_LIMIT    = 1'b1;

    localparam int CNT_W   = 17;
    localparam int CFG_W   = 17;

    localparam logic [CNT_W-1:0] COUNT_MAX     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] TEXT_TAG_LEN  = 17'd5;
    localparam logic [CNT_W-1:0] BIN_SIG_LEN   = 17'd12;
    localparam logic [CNT_W-1:0] LEN_OFFSET_HI = 17'd14;
    localparam logic [CNT_W-1:0] LEN_OFFSET_LO = 17'd15;
    localparam logic [CNT_W-1:0] BIN_FIXED_LEN = 17'd16;
    localparam logic [7:0]       NEWLINE       = 8'h0A;

    localparam logic [7:0]       TEXT_MAX_LEN_RST = 8'd107;
    localparam logic [CFG_W-1:0] BIN_LIMIT_RST    = 17'd10000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_php_in;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] header_length;
    } t_php_out;

    // per-byte record passed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] count;      // bytes seen including this one
        logic             n_lt_sig;   // count below text signature length
        logic             n_ge_fix;   // count reached binary fixed part
        logic             n_ge_total; // whole binary header arrived
        logic             text_ok;
        logic             bin_ok;
        logic [CNT_W-1:0] nl_len;     // 0: no newline yet
        logic [CNT_W-1:0] bin_total;
    } t_php_rec;

    // "PROXY"
    function automatic logic [7:0] text_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h50;
            3'd1:    v = 8'h52;
            3'd2:    v = 8'h4F;
            3'd3:    v = 8'h58;
            default: v = 8'h59;
        endcase
        return v;
    endfunction

    // 0D 0A 0D 0A 00 0D 0A 51 55 49 54 0A
    function automatic logic [7:0] bin_sig_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h0D;
            4'd1:    v = 8'h0A;
            4'd2:    v = 8'h0D;
            4'd3:    v = 8'h0A;
            4'd4:    v = 8'h00;
            4'd5:    v = 8'h0D;
            4'd6:    v = 8'h0A;
            4'd7:    v = 8'h51;
            4'd8:    v = 8'h55;
            4'd9:    v = 8'h49;
            4'd10:   v = 8'h54;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/proxy_header_preclassifier.sv
// ----------------------------------------------------------------------------
// proxy_header_preclassifier
// Byte-serial classifier for connection-preamble proxy headers (text/binary).
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | in        | i_in_valid / o_in_stall   | i_in_item  (data_byte, start_req)
//  out     | out       | o_out_valid / i_out_stall | o_out_item (kind, header_length)
//  cfg     | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  One item per cycle sustained unless the output stalls; each input item yields
//  exactly one result item. A result passes the queue, then the result register:
//  the front updates prefix state at acceptance, the back classifies the queue head.
//  o_in_stall rises only when the queue holds two records (output stalled).
//  Reset is synchronous, active low; it restores register defaults (107, 10000)
//  and clears all connection state, the queue fill and the output valid flag.
//
`default_nettype none

module proxy_header_preclassifier (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input items
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire php_pkg::t_php_in          i_in_item,
    // result items
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output php_pkg::t_php_out              o_out_item,
    // configuration writes
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [php_pkg::CFG_W-1:0] i_cfg_data
);
    import php_pkg::*;

    logic     in_accept;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_php_rec front_rec;
    t_php_rec q_rec;

    // the queue decouples the stalls: input stalls only when it is full
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // front: per-byte state tracking, builds a record per item
    php_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_rec    (front_rec)
    );

    php_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_rec   (front_rec),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    // back: limit checks and result register
    php_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_rec      (q_rec),
        .o_pop      (q_pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_item)
    );

endmodule

`default_nettype wire

### hdl/php_front.sv
// ----------------------------------------------------------------------------
// php_front
// Per-connection byte tracker: updates prefix state and emits a record.
// ----------------------------------------------------------------------------
`default_nettype none

module php_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire php_pkg::t_php_in  i_item,
    output php_pkg::t_php_rec      o_rec
);
    import php_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_tm, n_tm;
    logic             r_bm, n_bm;
    logic [CNT_W-1:0] r_nl, n_nl;
    logic [7:0]       r_hi, n_hi;
    logic [7:0]       r_lo, n_lo;

    logic [CNT_W-1:0] pos;
    logic             base_tm, base_bm;
    logic [CNT_W-1:0] base_nl;
    logic [7:0]       base_hi, base_lo, b;
    logic [CNT_W-1:0] total;

    always_comb begin
        b       = i_item.data_byte;
        // start flag clears state before the byte is taken
        pos     = i_item.start_req ? '0 : r_cnt;
        base_tm = i_item.start_req ? 1'b1 : r_tm;
        base_bm = i_item.start_req ? 1'b1 : r_bm;
        base_nl = i_item.start_req ? '0 : r_nl;
        base_hi = i_item.start_req ? 8'd0 : r_hi;
        base_lo = i_item.start_req ? 8'd0 : r_lo;

        n_cnt = (pos == COUNT_MAX) ? pos : pos + 17'd1;
        n_tm  = base_tm;
        if (pos < TEXT_TAG_LEN && b != text_sig_byte(pos[2:0])) begin
            n_tm = 1'b0;
        end
        n_bm  = base_bm;
        if (pos < BIN_SIG_LEN && b != bin_sig_byte(pos[3:0])) begin
            n_bm = 1'b0;
        end
        n_hi = (pos == LEN_OFFSET_HI) ? b : base_hi;
        n_lo = (pos == LEN_OFFSET_LO) ? b : base_lo;
        n_nl = (b == NEWLINE && base_nl == '0) ? n_cnt : base_nl;

        total = BIN_FIXED_LEN + {1'b0, n_hi, n_lo};

        o_rec.count      = n_cnt;
        o_rec.n_lt_sig   = n_cnt < TEXT_TAG_LEN;
        o_rec.n_ge_fix   = n_cnt >= BIN_FIXED_LEN;
        o_rec.n_ge_total = n_cnt >= total;
        o_rec.text_ok    = n_tm;
        o_rec.bin_ok     = n_bm;
        o_rec.nl_len     = n_nl;
        o_rec.bin_total  = total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_tm  <= 1'b1;
            r_bm  <= 1'b1;
            r_nl  <= '0;
            r_hi  <= 8'd0;
            r_lo  <= 8'd0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
            r_tm  <= n_tm;
            r_bm  <= n_bm;
            r_nl  <= n_nl;
            r_hi  <= n_hi;
            r_lo  <= n_lo;
        end
    end

endmodule

`default_nettype wire

### hdl/php_queue.sv
// ----------------------------------------------------------------------------
// php_queue
// Two-entry record queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module php_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire php_pkg::t_php_rec i_rec,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output php_pkg::t_php_rec      o_rec
);
    import php_pkg::*;

    logic [1:0] r_fill, n_fill;
    t_php_rec   r_q0, r_q1;

    assign o_full  = r_fill == 2'd2;
    assign o_valid = r_fill != 2'd0;
    assign o_rec   = r_q0;

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // head in q0, tail in q1
    always_ff @(posedge i_clk) begin
        case (r_fill)
            2'd0: begin
                if (i_push) begin
                    r_q0 <= i_rec;
                end
            end
            2'd1: begin
                if (i_push && i_pop) begin
                    r_q0 <= i_rec;
                end else if (i_push) begin
                    r_q1 <= i_rec;
                end
            end
            default: begin
                if (i_pop) begin
                    r_q0 <= r_q1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/php_back.sv
// ----------------------------------------------------------------------------
// php_back
// Classifies queued records against the limits and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module php_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_idx,
    input  wire logic [php_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                     i_q_valid,
    input  wire php_pkg::t_php_rec        i_rec,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output php_pkg::t_php_out             o_item
);
    import php_pkg::*;

    logic [7:0]       r_tml;
    logic [CFG_W-1:0] r_limit;
    logic             r_vld;
    t_php_out         r_item, n_item;

    assign o_pop   = i_q_valid && (!r_vld || !i_stall);
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_comb begin
        n_item.kind          = KIND_NOT_PROXY;
        n_item.header_length = '0;
        if (i_rec.n_lt_sig) begin
            n_item.kind = KIND_NEED_MORE;
        end else if (i_rec.text_ok) begin
            if (i_rec.nl_len != '0) begin
                if (i_rec.nl_len <= {9'd0, r_tml}) begin
                    n_item.kind          = KIND_TEXT;
                    n_item.header_length = i_rec.nl_len;
                end
            end else if (i_rec.count < {9'd0, r_tml}) begin
                n_item.kind = KIND_NEED_MORE;
            end
        end else if (i_rec.bin_ok) begin
            if (i_rec.n_ge_fix) begin
                if (i_rec.bin_total < r_limit) begin
                    n_item.header_length = i_rec.bin_total;
                    n_item.kind = i_rec.n_ge_total ? KIND_BINARY : KIND_NEED_MORE;
                end
            end else begin
                n_item.kind = KIND_NEED_MORE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tml   <= TEXT_MAX_LEN_RST;
            r_limit <= BIN_LIMIT_RST;
            r_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TEXT_MAX_LEN: r_tml   <= i_cfg_data[7:0];
                    CFG_BIN_LIMIT:    r_limit <= i_cfg_data;
                    default:          r_tml   <= r_tml;
                endcase
            end
            if (o_pop) begin
                r_vld <= 1'b1;
            end else if (!i_stall) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

### hdl/php_checker.sv
// ----------------------------------------------------------------------------
// php_checker
// Port-level checks on the pre-classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module php_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire php_pkg::t_php_out         o_out_item
);
    import php_pkg::*;

    // no result item right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_not_proxy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_NOT_PROXY
            |-> o_out_item.header_length == '0)
        else $error("not-proxy result with length");

    // text length counts "PROXY" plus newline and is bounded by an 8-bit limit
    a_text_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_TEXT
            |-> o_out_item.header_length >= 17'd6 && o_out_item.header_length <= 17'd255)
        else $error("text length out of range");

    a_bin_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_BINARY
            |-> o_out_item.header_length >= BIN_FIXED_LEN)
        else $error("binary length below fixed part");

endmodule

bind proxy_header_preclassifier php_checker u_php_checker (.*);

`default_nettype wire
